>>> src/fspa_pkg.sv
`timescale 1ns / 1ps
// fspa_pkg: widths, codes and shared types of the fixed slot pool allocator
// used by the top level, the divider and the checker; no dependencies

package fspa_pkg;

  // pool geometry
  localparam int SLOTS   = 1024;
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int LINK_W  = SLOT_W + 1;     // link or slot count, holds SLOTS itself

  // field widths
  localparam int ADDR_W    = 48;
  localparam int BYTES_W   = 32;
  localparam int SIZE_W    = 13;
  localparam int ALIGN_W   = 8;
  localparam int COUNT_W   = 11;
  localparam int OP_W      = 2;
  localparam int CFG_IDX_W = 2;
  localparam int PROD_W    = SLOT_W + SIZE_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // reset register values
  localparam logic [ADDR_W-1:0]  POOL_BASE_RST  = '0;
  localparam logic [BYTES_W-1:0] POOL_BYTES_RST = BYTES_W'(65536);
  localparam logic [SIZE_W-1:0]  OBJ_SIZE_RST   = SIZE_W'(64);
  localparam logic [ALIGN_W-1:0] OBJ_ALIGN_RST  = ALIGN_W'(8);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BYTES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OBJ_SIZE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OBJ_ALIGN  = 2'd3;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  // result status codes
  localparam logic ST_DONE      = 1'b0;
  localparam logic ST_EXHAUSTED = 1'b1;

  // divider handshake
  typedef struct packed {
    logic               start;
    logic [BYTES_W-1:0] dividend;
    logic [SIZE_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [BYTES_W-1:0] quotient;
  } div_rsp_t;

endpackage

>>> src/fspa_ram.sv
`timescale 1ns / 1ps
// fspa_ram: generic simple dual port ram, one write and one registered read port
// no dependencies

module fspa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> src/fspa_div.sv
`timescale 1ns / 1ps
// fspa_div: restoring divider, one quotient bit per cycle
// depends on fspa_pkg for widths and the request and response structs

module fspa_div import fspa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(BYTES_W);

  logic               busy_r;
  logic               done_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [BYTES_W-1:0] num_r;     // dividend bits shift out, quotient bits shift in
  logic [SIZE_W-1:0]  rem_r;
  logic [SIZE_W-1:0]  den_r;

  logic [SIZE_W:0]    trial;
  logic               q_bit;
  logic [SIZE_W:0]    trial_diff;

  assign trial      = {rem_r, num_r[BYTES_W-1]};
  assign q_bit      = (trial >= {1'b0, den_r});
  assign trial_diff = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        num_r  <= req.dividend;
        den_r  <= req.divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        num_r <= {num_r[BYTES_W-2:0], q_bit};
        rem_r <= q_bit ? trial_diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(BYTES_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = num_r;

endmodule

>>> src/fixed_slot_pool_allocator_unit.sv
`timescale 1ns / 1ps
// fixed_slot_pool_allocator_unit: top level of the fixed slot pool allocator
// depends on fspa_pkg, fspa_ram (next-slot table) and fspa_div (slot count)

// Fixed-size slot allocator with a last-in-first-out free list kept in a
// 1024-entry next-slot table (one ram, registered read). Allocate pops the
// head slot and returns its index and address (aligned base plus slot times
// object size), or status exhausted; free pushes a slot back (slots not below
// the slot count are ignored, double frees are not checked); clear latches the
// configuration, aligns the base, divides the remaining bytes by the object
// size and rebuilds the list. Configuration takes effect only at the next
// clear. Allocate, free and unused codes pass through the response state: the
// table read is issued on acceptance, and the read-modify-write and the result
// register follow in the response state, which waits while the result is
// stalled; no new transaction is accepted until the last one is through. A clear
// runs a bit-serial divide (skipped if no slot fits) and then a sweep that
// rewrites all 1024 table entries one per cycle before its result. After reset
// the same rebuild runs with the reset register values before the first
// transaction is accepted; configuration writes are taken at any time (cfg_ready is always high).

module fixed_slot_pool_allocator_unit import fspa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // request channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [OP_W-1:0]      in_op,
  input  logic [SLOT_W-1:0]    in_slot_index,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_status,
  output logic [SLOT_W-1:0]    out_granted_slot,
  output logic [ADDR_W-1:0]    out_granted_address,
  output logic [COUNT_W-1:0]   out_live_allocations,
  output logic [BYTES_W-1:0]   out_bytes_in_use,
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data
);

  typedef enum logic [4:0] {
    S_PREP  = 5'b00001,   // latch configuration, start the slot count divide if slots fit
    S_DIV   = 5'b00010,   // wait for the quotient
    S_SWEEP = 5'b00100,   // relink every table entry in order
    S_IDLE  = 5'b01000,   // ready for a transaction
    S_RESP  = 5'b10000    // read-modify-write and load the result
  } state_t;

  localparam int MEM_W = LINK_W + 1;   // {end of list, link}

  // configuration registers
  logic [ADDR_W-1:0]  pool_base_r;
  logic [BYTES_W-1:0] pool_bytes_r;
  logic [SIZE_W-1:0]  object_size_r;
  logic [ALIGN_W-1:0] object_alignment_r;

  // allocator state
  state_t             state_r, state_nxt;
  logic               report_r;        // a clear transaction waits for its result
  logic [LINK_W-1:0]  free_head_r, free_head_nxt;
  logic               head_empty_r, head_empty_nxt;
  logic [LINK_W-1:0]  slot_total_r;
  logic [ADDR_W-1:0]  aligned_start_r;
  logic [SIZE_W-1:0]  held_size_r;
  logic [COUNT_W-1:0] alloc_count_r, alloc_count_nxt;
  logic [BYTES_W-1:0] used_bytes_r, used_bytes_nxt;
  logic [SLOT_W-1:0]  sweep_r;

  // latched transaction
  logic [OP_W-1:0]    op_r;
  logic [SLOT_W-1:0]  idx_r;
  logic [PROD_W-1:0]  prod_r;          // head slot times object size

  // result register
  logic               out_valid_r;
  logic               status_nxt;
  logic [SLOT_W-1:0]  gslot_nxt;
  logic [ADDR_W-1:0]  gaddr_nxt;

  // table ports
  logic               mem_wr_en;
  logic [SLOT_W-1:0]  mem_wr_addr;
  logic [MEM_W-1:0]   mem_wr_data;
  logic               mem_rd_en;
  logic [MEM_W-1:0]   mem_rd_data;

  div_req_t           div_req;
  div_rsp_t           div_rsp;

  // handshakes
  logic accept;
  logic out_free;
  logic resp_fire;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign resp_fire = (state_r == S_RESP) && out_free;
  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------
  // rebuild arithmetic
  // ---------------------------------------------------------------
  logic [ALIGN_W-1:0] align_mask;
  logic               align_pow2;
  logic [ALIGN_W-1:0] adj;
  logic               slots_fit;
  logic [LINK_W-1:0]  slot_count_sat;

  assign align_mask = object_alignment_r - ALIGN_W'(1);
  // non power of two alignment means no adjustment
  assign align_pow2 = (object_alignment_r != '0) && ((object_alignment_r & align_mask) == '0);
  assign adj        = align_pow2 ? ((~pool_base_r[ALIGN_W-1:0] + ALIGN_W'(1)) & align_mask)
                                 : '0;
  // zero object size or a pool smaller than the adjustment gives an empty list
  assign slots_fit  = (object_size_r != '0) && (pool_bytes_r >= BYTES_W'(adj));

  assign div_req.start    = (state_r == S_PREP) && slots_fit;
  assign div_req.dividend = pool_bytes_r - BYTES_W'(adj);
  assign div_req.divisor  = object_size_r;

  assign slot_count_sat = (div_rsp.quotient > BYTES_W'(SLOTS)) ? LINK_W'(SLOTS)
                                                               : div_rsp.quotient[LINK_W-1:0];

  fspa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // ---------------------------------------------------------------
  // sweep relinks slot i to i plus one, last counted slot ends the list
  // ---------------------------------------------------------------
  logic [LINK_W-1:0] sweep_link;
  logic              sweep_last;

  assign sweep_link = LINK_W'(sweep_r) + LINK_W'(1);
  assign sweep_last = (sweep_r == SLOT_W'(SLOTS - 1));

  // ---------------------------------------------------------------
  // read-modify-write of the list head
  // ---------------------------------------------------------------
  logic               alloc_ok;
  logic               free_ok;
  logic [BYTES_W:0]   bytes_sum;
  logic [BYTES_W-1:0] bytes_inc;
  logic [BYTES_W-1:0] bytes_dec;
  logic [COUNT_W-1:0] count_inc;
  logic [COUNT_W-1:0] count_dec;
  logic [LINK_W-1:0]  rd_link;
  logic               rd_end;

  assign {rd_end, rd_link} = mem_rd_data;

  // the head points past the table only on an empty list, checked anyway
  assign alloc_ok  = !head_empty_r && (free_head_r < LINK_W'(SLOTS));
  assign free_ok   = ({1'b0, idx_r} < slot_total_r);

  // saturating usage counters
  assign bytes_sum = {1'b0, used_bytes_r} + (BYTES_W + 1)'(held_size_r);
  assign bytes_inc = bytes_sum[BYTES_W] ? '1 : bytes_sum[BYTES_W-1:0];
  assign bytes_dec = (used_bytes_r < BYTES_W'(held_size_r)) ? '0
                                                            : used_bytes_r - BYTES_W'(held_size_r);
  assign count_inc = (alloc_count_r == COUNT_MAX) ? alloc_count_r
                                                  : alloc_count_r + COUNT_W'(1);
  assign count_dec = (alloc_count_r == '0) ? alloc_count_r : alloc_count_r - COUNT_W'(1);

  // head read is issued on acceptance of an allocate; nothing else reads the table, and the
  // only writes (free push, sweep) finish before the next acceptance
  assign mem_rd_en = accept && (in_op == OP_ALLOC);

  always_comb begin
    state_nxt       = state_r;
    free_head_nxt   = free_head_r;
    head_empty_nxt  = head_empty_r;
    alloc_count_nxt = alloc_count_r;
    used_bytes_nxt  = used_bytes_r;
    status_nxt      = ST_DONE;
    gslot_nxt       = '0;
    gaddr_nxt       = '0;
    mem_wr_en       = 1'b0;
    mem_wr_addr     = sweep_r;
    mem_wr_data     = {(sweep_link >= slot_total_r), sweep_link};

    case (state_r)
      S_PREP: begin
        free_head_nxt   = '0;
        head_empty_nxt  = 1'b1;
        alloc_count_nxt = '0;
        used_bytes_nxt  = '0;
        state_nxt       = slots_fit ? S_DIV : S_SWEEP;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          head_empty_nxt = (slot_count_sat == '0);
          state_nxt      = S_SWEEP;
        end
      end
      S_SWEEP: begin
        mem_wr_en = 1'b1;
        if (sweep_last) begin
          state_nxt = report_r ? S_RESP : S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = (in_op == OP_CLEAR) ? S_PREP : S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
          case (op_r)
            OP_ALLOC: begin
              if (alloc_ok) begin
                gslot_nxt       = free_head_r[SLOT_W-1:0];
                gaddr_nxt       = aligned_start_r + ADDR_W'(prod_r);
                free_head_nxt   = rd_link;
                head_empty_nxt  = rd_end;
                alloc_count_nxt = count_inc;
                used_bytes_nxt  = bytes_inc;
              end else begin
                status_nxt = ST_EXHAUSTED;
              end
            end
            OP_FREE: begin
              if (free_ok) begin
                mem_wr_en       = 1'b1;
                mem_wr_addr     = idx_r;
                mem_wr_data     = {head_empty_r, free_head_r};
                free_head_nxt   = {1'b0, idx_r};
                head_empty_nxt  = 1'b0;
                alloc_count_nxt = count_dec;
                used_bytes_nxt  = bytes_dec;
              end
            end
            default: begin
              // clear result and unused code: counters as they stand
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_PREP;
      end
    endcase
  end

  fspa_ram #(
    .WIDTH (MEM_W),
    .DEPTH (SLOTS)
  ) u_next_slot (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (free_head_r[SLOT_W-1:0]),
    .rd_data (mem_rd_data)
  );

  // ---------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_base_r        <= POOL_BASE_RST;
      pool_bytes_r       <= POOL_BYTES_RST;
      object_size_r      <= OBJ_SIZE_RST;
      object_alignment_r <= OBJ_ALIGN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_POOL_BASE:  pool_base_r        <= cfg_data;
        CFG_POOL_BYTES: pool_bytes_r       <= cfg_data[BYTES_W-1:0];
        CFG_OBJ_SIZE:   object_size_r      <= cfg_data[SIZE_W-1:0];
        CFG_OBJ_ALIGN:  object_alignment_r <= cfg_data[ALIGN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------
  // control and list state
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_PREP;
      report_r      <= 1'b0;
      free_head_r   <= '0;
      head_empty_r  <= 1'b1;
      alloc_count_r <= '0;
      used_bytes_r  <= '0;
      sweep_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      free_head_r   <= free_head_nxt;
      head_empty_r  <= head_empty_nxt;
      alloc_count_r <= alloc_count_nxt;
      used_bytes_r  <= used_bytes_nxt;

      if (state_r == S_PREP) begin
        sweep_r <= '0;
      end else if (state_r == S_SWEEP) begin
        sweep_r <= sweep_r + SLOT_W'(1);
      end

      if (accept) begin
        report_r <= (in_op == OP_CLEAR);
      end

      if (resp_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // rebuild parameters, latched at clear
  always_ff @(posedge clk) begin
    if (state_r == S_PREP) begin
      aligned_start_r <= pool_base_r + ADDR_W'(adj);
      held_size_r     <= object_size_r;
      slot_total_r    <= '0;
    end else if ((state_r == S_DIV) && div_rsp.done) begin
      slot_total_r    <= slot_count_sat;
    end
  end

  // transaction payload and slot offset product
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_op;
      idx_r  <= in_slot_index;
      prod_r <= PROD_W'(free_head_r[SLOT_W-1:0]) * PROD_W'(held_size_r);
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (resp_fire) begin
      out_status           <= status_nxt;
      out_granted_slot     <= gslot_nxt;
      out_granted_address  <= gaddr_nxt;
      out_live_allocations <= alloc_count_nxt;
      out_bytes_in_use     <= used_bytes_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> src/fspa_checker.sv
`timescale 1ns / 1ps
// fspa_checker: port level assertions for the fixed slot pool allocator
// depends on fspa_pkg; bound to fixed_slot_pool_allocator_unit below

module fspa_checker import fspa_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic               out_status,
  input logic [SLOT_W-1:0]  out_granted_slot,
  input logic [ADDR_W-1:0]  out_granted_address,
  input logic [COUNT_W-1:0] out_live_allocations,
  input logic [BYTES_W-1:0] out_bytes_in_use
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_granted_slot) && $stable(out_granted_address) &&
      $stable(out_live_allocations) && $stable(out_bytes_in_use))
    else $error("stalled result changed");

  // the block works on one transaction at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("transaction accepted while previous one in progress");

  // a failed allocate grants nothing
  a_exhausted_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_EXHAUSTED) |->
      (out_granted_slot == '0) && (out_granted_address == '0))
    else $error("exhausted result carries a grant");

  // a new result only comes out of a transaction in progress
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a transaction in progress");

endmodule

bind fixed_slot_pool_allocator_unit fspa_checker u_fspa_checker (.*);
